### rtl/tws_pkg.sv
`default_nettype none

package tws_pkg;

  // sample format
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 1;

  // tanh table
  localparam int TANH_ENTRIES = 256;
  localparam int TAB_IDX_W    = $clog2(TANH_ENTRIES + 1);
  localparam int FR_BITS      = 19;
  localparam int TAB_W        = 32;
  localparam int TAB_SHIFT    = 31 - FRAC;

  // datapath widths
  localparam int MUL_A_W = 38;
  localparam int MUL_B_W = 26;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int ARG_W   = 27;
  localparam int P_W     = ARG_W + TAB_IDX_W;
  localparam int TH_W    = SAMPLE_BITS + 1;
  localparam int Y_W     = SAMPLE_BITS + 2;
  localparam int HP_W    = 32;
  localparam int WET_W   = 36;
  localparam int MIX_W   = MUL_A_W;

  // apb
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int DATA_W   = 32;

  localparam logic [16:0] ONE_Q16         = 17'd65536;
  localparam logic [17:0] ONE_POINT_EIGHT = 18'd117965;

  // reset values
  localparam logic [24:0]        PRE_GAIN_RST   = 25'd524288;
  localparam logic signed [19:0] PRE_OFFSET_RST = 20'sd0;
  localparam logic [16:0]        SHAPE_NORM_RST = 17'd70345;
  localparam logic [15:0]        HP_COEFF_RST   = 16'd65459;
  localparam logic [16:0]        TONE_MIX_RST   = 17'd36045;
  localparam logic [16:0]        WET_GAIN_RST   = 17'd45875;
  localparam logic [17:0]        OUT_GAIN_RST   = 18'd32845;

  typedef enum logic [2:0] {
    REG_PRE_GAIN,
    REG_PRE_OFFSET,
    REG_SHAPE_NORM,
    REG_HP_COEFF,
    REG_TONE_MIX,
    REG_WET_GAIN,
    REG_OUT_GAIN,
    REG_BYPASS
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRE,
    ST_ARG_A,
    ST_T_IDX,
    ST_T_RD0,
    ST_T_RD1,
    ST_T_MUL,
    ST_T_FIN,
    ST_Y_MUL,
    ST_Y,
    ST_HP_MUL,
    ST_HP,
    ST_T2_MUL,
    ST_ARG_T2,
    ST_TONE_MUL,
    ST_WET,
    ST_DRY_MUL,
    ST_WET_MUL,
    ST_MIX,
    ST_OG_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic en;
    logic accum;
  } mac_ctl_t;

  typedef logic [TAB_W-1:0] tanh_tab_t [0:TANH_ENTRIES];

  // per-entry exponent step in Q.32
  localparam logic [127:0] EXP_STEP = (128'd16 << 32) / TANH_ENTRIES;

  // unsigned long division by shift and subtract
  function automatic logic [127:0] udiv(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q;
    logic [127:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 127; b >= 0; b--) begin
      rem = {rem[126:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8*i/N) in Q.31, built at elaboration from an integer exp series
  function automatic tanh_tab_t build_tanh_table();
    tanh_tab_t   tab;
    logic [127:0] a;
    logic [127:0] term;
    logic [127:0] r;
    logic [127:0] e;
    logic [127:0] den;
    logic [127:0] num;
    a    = EXP_STEP;
    term = 128'd1 << 32;
    r    = 128'd1 << 32;
    e    = 128'd1 << 32;
    for (int k = 1; k <= 15; k++) begin
      term = udiv((term * a) >> 32, 128'(k));
      if (k[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      den    = (128'd1 << 32) + e;
      num    = ((128'd1 << 32) - e) << 31;
      tab[i] = TAB_W'(udiv(num + (den >> 1), den));
      e      = (e * r + (128'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_table();

  localparam logic signed [ACC_W-1:0] ONE_W = 1;

  // rounding right shift, halves up
  function automatic logic signed [ACC_W-1:0] rs(input logic signed [ACC_W-1:0] v,
                                                 input int unsigned s);
    return (v + (ONE_W <<< (s - 1))) >>> s;
  endfunction

endpackage

`default_nettype wire

### rtl/tws_if.sv
`default_nettype none

interface tws_in_if import tws_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          block_start;

  modport source (output valid, output in_sample, output block_start, input ready);
  modport sink   (input valid, input in_sample, input block_start, output ready);
endinterface

interface tws_out_if import tws_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

### rtl/tws_mac.sv
`default_nettype none

module tws_mac import tws_pkg::*; (
  input  wire logic                      clk_i,
  input  wire mac_ctl_t                  ctl_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output logic signed [ACC_W-1:0]        acc_o
);

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] acc_d;

  // multiply, optionally add to the previous product
  always_comb begin
    acc_d = (ctl_i.accum ? acc_q : '0) + ACC_W'(a_i * b_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

### rtl/tanh_waveshaper_distortion.sv
`default_nettype none

// tanh waveshaper distortion, one mono channel. each accepted transfer carries a signed
// Q1.23 sample and a block-start flag and produces exactly one Q1.23 sample: pre-gain and
// offset, tanh shaping scaled by 1/tanh(shape), a one-pole high-pass (cleared on block
// start), a blend of its output hp toward tanh(1.8*hp), dry/wet mix and output gain with
// 24-bit saturation. tanh comes from a 257-entry table with linear interpolation and
// saturates beyond |a|>=8. all products go through one shared 38x26 multiply-accumulate
// under a small sequencer: after the idle state that takes the transfer come two table
// lookups, eight further products, six rounding steps and the output load; with bypass set
// it goes straight from idle to the output load, which waits while an earlier result is
// still held in the output register. the result waits in an output register; the next
// input is taken while it waits. configuration sits on an apb port, register i at byte
// address 4*i; the user must see it is written only while idle, not enforced by the block.
module tanh_waveshaper_distortion import tws_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  tws_in_if.sink                 in_i,
  tws_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // configuration registers
  logic [24:0]        pre_gain_q;
  logic signed [19:0] pre_offset_q;
  logic [16:0]        shape_norm_q;
  logic [15:0]        hp_coeff_q;
  logic [16:0]        tone_mix_q;
  logic [16:0]        wet_gain_q;
  logic [17:0]        out_gain_q;
  logic               bypass_q;

  cfg_reg_e cfg_idx;
  logic     cfg_wr;

  // sequencer and filter state
  state_e                   state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  logic                     pass_q;
  logic signed [HP_W-1:0]   hp_q;
  logic signed [Y_W-1:0]    prev_q;

  // datapath payload
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic signed [ARG_W-1:0]       arg_q;
  logic [TAB_IDX_W-1:0]          idx_q;
  logic [FR_BITS-1:0]            fr_q;
  logic                          neg_q;
  logic [TAB_W-1:0]              t0_q, t1_q;
  logic signed [TH_W-1:0]        th_q;
  logic signed [Y_W-1:0]         y_q;
  logic signed [WET_W-1:0]       wet_q;
  logic signed [MIX_W-1:0]       mix_q;

  // shared multiply-accumulate
  mac_ctl_t                   mac_ctl;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]    acc;

  logic in_xfer;
  logic fin_load;

  // ------------------------------------------------------------------ apb
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      REG_PRE_GAIN:   prdata = DATA_W'(pre_gain_q);
      REG_PRE_OFFSET: prdata = DATA_W'(pre_offset_q);
      REG_SHAPE_NORM: prdata = DATA_W'(shape_norm_q);
      REG_HP_COEFF:   prdata = DATA_W'(hp_coeff_q);
      REG_TONE_MIX:   prdata = DATA_W'(tone_mix_q);
      REG_WET_GAIN:   prdata = DATA_W'(wet_gain_q);
      REG_OUT_GAIN:   prdata = DATA_W'(out_gain_q);
      REG_BYPASS:     prdata = DATA_W'(bypass_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_gain_q   <= PRE_GAIN_RST;
      pre_offset_q <= PRE_OFFSET_RST;
      shape_norm_q <= SHAPE_NORM_RST;
      hp_coeff_q   <= HP_COEFF_RST;
      tone_mix_q   <= TONE_MIX_RST;
      wet_gain_q   <= WET_GAIN_RST;
      out_gain_q   <= OUT_GAIN_RST;
      bypass_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PRE_GAIN:   pre_gain_q   <= pwdata[24:0];
        REG_PRE_OFFSET: pre_offset_q <= $signed(pwdata[19:0]);
        REG_SHAPE_NORM: shape_norm_q <= pwdata[16:0];
        REG_HP_COEFF:   hp_coeff_q   <= pwdata[15:0];
        REG_TONE_MIX:   tone_mix_q   <= pwdata[16:0];
        REG_WET_GAIN:   wet_gain_q   <= pwdata[16:0];
        REG_OUT_GAIN:   out_gain_q   <= pwdata[17:0];
        REG_BYPASS:     bypass_q     <= pwdata[0];
        default:        ;
      endcase
    end
  end

  // ------------------------------------------------------------------ handshake
  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_xfer          = in_i.valid & in_i.ready;
  assign fin_load         = (state_q == ST_FIN) & (~out_valid_q | out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_sample_q;

  // ------------------------------------------------------------------ sequencer
  // dry weight may go negative when wet gain exceeds unity
  logic signed [17:0] dry_w;
  assign dry_w = $signed({1'b0, ONE_Q16}) - $signed({1'b0, wet_gain_q});

  always_comb begin
    state_d     = state_q;
    mac_ctl     = '0;
    mul_a       = '0;
    mul_b       = '0;
    out_valid_d = fin_load | (out_valid_q & ~out_o.ready);
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = bypass_q ? ST_FIN : ST_PRE;
        end
      end
      ST_PRE: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(x_q);
        mul_b      = $signed({1'b0, pre_gain_q});
        state_d    = ST_ARG_A;
      end
      ST_ARG_A: state_d = ST_T_IDX;
      ST_T_IDX: state_d = ST_T_RD0;
      ST_T_RD0: state_d = ST_T_RD1;
      ST_T_RD1: state_d = ST_T_MUL;
      ST_T_MUL: begin
        // interpolation step: slope times fraction
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'($signed({1'b0, t1_q - t0_q}));
        mul_b      = MUL_B_W'($signed({1'b0, fr_q}));
        state_d    = ST_T_FIN;
      end
      ST_T_FIN: state_d = pass_q ? ST_TONE_MUL : ST_Y_MUL;
      ST_Y_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(th_q);
        mul_b      = MUL_B_W'($signed({1'b0, shape_norm_q}));
        state_d    = ST_Y;
      end
      ST_Y: state_d = ST_HP_MUL;
      ST_HP_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(hp_q) + MUL_A_W'(y_q) - MUL_A_W'(prev_q);
        mul_b      = MUL_B_W'($signed({1'b0, hp_coeff_q}));
        state_d    = ST_HP;
      end
      ST_HP: state_d = ST_T2_MUL;
      ST_T2_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(hp_q);
        mul_b      = MUL_B_W'($signed({1'b0, ONE_POINT_EIGHT}));
        state_d    = ST_ARG_T2;
      end
      ST_ARG_T2: state_d = ST_T_IDX;
      ST_TONE_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(th_q) - MUL_A_W'(hp_q);
        mul_b      = MUL_B_W'($signed({1'b0, tone_mix_q}));
        state_d    = ST_WET;
      end
      ST_WET: state_d = ST_DRY_MUL;
      ST_DRY_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = MUL_A_W'(x_q);
        mul_b      = MUL_B_W'(dry_w);
        state_d    = ST_WET_MUL;
      end
      ST_WET_MUL: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.accum = 1'b1;
        mul_a         = MUL_A_W'(wet_q);
        mul_b         = MUL_B_W'($signed({1'b0, wet_gain_q}));
        state_d       = ST_MIX;
      end
      ST_MIX: state_d = ST_OG_MUL;
      ST_OG_MUL: begin
        mac_ctl.en = 1'b1;
        mul_a      = mix_q;
        mul_b      = MUL_B_W'($signed({1'b0, out_gain_q}));
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (fin_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  tws_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .acc_o (acc)
  );

  // ------------------------------------------------------------------ datapath
  logic [ARG_W-1:0]           mag;
  logic [P_W-1:0]             pos;
  logic [P_W-FR_BITS-1:0]     idx_full;
  logic                       tab_sat;
  logic [TAB_W:0]             tsum;
  logic signed [ACC_W-1:0]    tmag;
  logic signed [ACC_W-1:0]    hp_r;
  logic signed [HP_W-1:0]     hp_sat;
  logic signed [ACC_W-1:0]    out_r;
  logic signed [SAMPLE_BITS-1:0] res;

  localparam logic signed [ACC_W-1:0] HP_MAX  = ACC_W'({1'b0, {(HP_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] HP_MIN  = -HP_MAX - ONE_W;
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ONE_W;

  always_comb begin
    // table position of |arg|
    mag      = arg_q[ARG_W-1] ? ARG_W'(-arg_q) : arg_q;
    pos      = P_W'(mag) * P_W'(TANH_ENTRIES);
    idx_full = pos[P_W-1:FR_BITS];
    tab_sat  = idx_full >= (P_W-FR_BITS)'(TANH_ENTRIES);

    // interpolated value in sample scale
    tsum = {1'b0, t0_q} + {1'b0, acc[FR_BITS +: TAB_W]};
    tmag = rs($signed(ACC_W'(tsum)), TAB_SHIFT);

    // high-pass with saturation at 32 bits
    hp_r = rs(acc, 16);
    if (hp_r > HP_MAX) begin
      hp_sat = HP_MAX[HP_W-1:0];
    end else if (hp_r < HP_MIN) begin
      hp_sat = HP_MIN[HP_W-1:0];
    end else begin
      hp_sat = hp_r[HP_W-1:0];
    end

    // final output gain and saturation
    out_r = rs(acc, 16);
    if (bypass_q) begin
      res = x_q;
    end else if (out_r > OUT_MAX) begin
      res = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (out_r < OUT_MIN) begin
      res = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      res = out_r[SAMPLE_BITS-1:0];
    end
  end

  // filter state, cleared on reset and on block start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q   <= '0;
      prev_q <= '0;
      pass_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        pass_q <= 1'b0;
        if (in_i.block_start) begin
          hp_q   <= '0;
          prev_q <= '0;
        end
      end
      if (state_q == ST_HP) begin
        hp_q   <= hp_sat;
        prev_q <= y_q;
      end
      if (state_q == ST_ARG_T2) begin
        pass_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= in_i.in_sample;
    end
    case (state_q)
      ST_ARG_A:  arg_q <= ARG_W'(rs(acc, FRAC)) + ARG_W'(pre_offset_q);
      ST_ARG_T2: arg_q <= ARG_W'(rs(acc, FRAC));
      ST_T_IDX: begin
        neg_q <= arg_q[ARG_W-1];
        idx_q <= tab_sat ? TAB_IDX_W'(TANH_ENTRIES) : idx_full[TAB_IDX_W-1:0];
        fr_q  <= tab_sat ? '0 : pos[FR_BITS-1:0];
      end
      ST_T_RD0: begin
        t0_q <= TANH_TAB[idx_q];
        if (idx_q != TAB_IDX_W'(TANH_ENTRIES)) begin
          idx_q <= idx_q + TAB_IDX_W'(1);
        end
      end
      ST_T_RD1: t1_q <= TANH_TAB[idx_q];
      ST_T_FIN: th_q <= neg_q ? -TH_W'(tmag) : TH_W'(tmag);
      ST_Y:     y_q  <= Y_W'(rs(acc, 16));
      ST_WET:   wet_q <= WET_W'(hp_q) + WET_W'(rs(acc, 16));
      ST_MIX:   mix_q <= MIX_W'(rs(acc, 16));
      default:  ;
    endcase
    if (fin_load) begin
      out_sample_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after an input transfer");

  a_block_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.block_start |=> hp_q == '0 && prev_q == '0)
    else $error("filter state not cleared on block start");

  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished result not presented");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && out_valid_q && !out_o.ready |=> state_q == ST_FIN)
    else $error("result overwrote a pending output");
`endif

endmodule

`default_nettype wire

### tb/sv/tanh_waveshaper_distortion_test.sv
`timescale 1ns / 1ps

module tanh_waveshaper_distortion_test;
  import tws_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tws_in_if  in_bus ();
  tws_out_if out_bus ();

  tanh_waveshaper_distortion u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the block's registers and filter state
  longint pre_gain_q, pre_offset_q, shape_norm_q, hp_coeff_q;
  longint tone_mix_q, wet_gain_q, out_gain_q, bypass_q;
  longint hp_acc, prev_y;
  longint tanh_lut [0:256];

  // samples still owed by the block, oldest first
  logic signed [SAMPLE_BITS-1:0] owed_samples [$];
  int mismatches;
  int samples_sent;
  int samples_seen;
  int bypass_seen;
  int block_starts;
  int burst_left;

  typedef struct {
    int                            phase;
    logic signed [SAMPLE_BITS-1:0] smp;
    bit                            bs;
    bit                            typed;
  } stim_row_t;

  // directed rows: phase 0 reset config, phase 1 bypass, phase 2 extreme config
  localparam int N_ROWS = 22;
  stim_row_t stim_rows [N_ROWS] = '{
    '{0, 24'sh7FFFFF, 1'b1, 1'b0},
    '{0, 24'sh800000, 1'b0, 1'b0},
    '{0, 24'sh000000, 1'b0, 1'b0},
    '{0, 24'sh000001, 1'b0, 1'b0},
    '{0, 24'shFFFFFF, 1'b0, 1'b0},
    '{0, 24'sh400000, 1'b1, 1'b0},
    '{0, 24'shC00000, 1'b0, 1'b0},
    '{0, 24'sh7FFFFF, 1'b0, 1'b0},
    '{1, 24'sh7FFFFF, 1'b0, 1'b1},
    '{1, 24'sh800000, 1'b1, 1'b1},
    '{1, 24'sh000000, 1'b0, 1'b1},
    '{1, 24'sh123456, 1'b0, 1'b1},
    '{1, 24'shAAAAAA, 1'b0, 1'b1},
    // extreme gains push |a| past the table end
    '{2, 24'sh7FFFFF, 1'b1, 1'b0},
    '{2, 24'sh800000, 1'b0, 1'b0},
    '{2, 24'sh7FFFFF, 1'b0, 1'b0},
    '{2, 24'sh800000, 1'b0, 1'b0},
    '{2, 24'sh000000, 1'b0, 1'b0},
    '{2, 24'sh000010, 1'b0, 1'b0},
    '{2, 24'sh7FFFFF, 1'b1, 1'b0},
    '{2, 24'sh555555, 1'b0, 1'b0},
    '{2, 24'sh800000, 1'b0, 1'b0}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // rounding right shift, halves up
  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // tanh(8*i/256) in Q.31 from a truncated exp series
  function automatic void fill_tanh_lut();
    logic [127:0] step, term, r, e, den, num;
    step = (128'd16 << 32) / 256;
    term = 128'd1 << 32;
    r    = 128'd1 << 32;
    e    = 128'd1 << 32;
    for (int k = 1; k <= 15; k++) begin
      term = ((term * step) >> 32) / k;
      if (k % 2 == 1) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i <= 256; i++) begin
      den         = (128'd1 << 32) + e;
      num         = ((128'd1 << 32) - e) << 31;
      tanh_lut[i] = longint'((num + den / 2) / den);
      e           = (e * r + (128'd1 << 31)) >> 32;
    end
  endfunction

  // Q.16 argument in, tanh in sample scale out; saturates past the table end
  function automatic longint tanh_q(longint arg);
    bit     neg;
    longint mag, p, idx, fr, t;
    neg = arg < 0;
    mag = neg ? -arg : arg;
    p   = mag * 256;
    idx = p >>> 19;
    if (idx >= 256) begin
      t = tanh_lut[256];
    end else begin
      fr = p & ((64'sd1 <<< 19) - 1);
      t  = tanh_lut[idx] + (((tanh_lut[idx + 1] - tanh_lut[idx]) * fr) >>> 19);
    end
    t = rnd_shift(t, 31 - FRAC);
    return neg ? -t : t;
  endfunction

  // one sample through the distortion chain, updates the filter state
  function automatic logic signed [SAMPLE_BITS-1:0] distort_sample(
      logic signed [SAMPLE_BITS-1:0] smp, bit bs);
    longint x, a, y, hp, t2, wet, mix;
    x = longint'(smp);
    if (bs) begin
      hp_acc = 0;
      prev_y = 0;
    end
    if (bypass_q != 0) return smp;
    a      = rnd_shift(x * pre_gain_q, FRAC) + pre_offset_q;
    y      = rnd_shift(tanh_q(a) * shape_norm_q, 16);
    hp     = rnd_shift(hp_coeff_q * (hp_acc + y - prev_y), 16);
    hp     = clamp_bits(hp, 32);
    hp_acc = hp;
    prev_y = y;
    t2     = tanh_q(rnd_shift(hp * 117965, FRAC));
    wet    = hp + rnd_shift((t2 - hp) * tone_mix_q, 16);
    mix    = rnd_shift(x * (65536 - wet_gain_q) + wet * wet_gain_q, 16);
    return SAMPLE_BITS'(clamp_bits(rnd_shift(mix * out_gain_q, 16), SAMPLE_BITS));
  endfunction

  // apb write: setup then access, mirrors the register into the model
  task automatic cfg_write(cfg_reg_e idx, logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PRE_GAIN:   pre_gain_q = val[24:0];
      REG_PRE_OFFSET: pre_offset_q = longint'($signed(val[19:0]));
      REG_SHAPE_NORM: shape_norm_q = val[16:0];
      REG_HP_COEFF:   hp_coeff_q = val[15:0];
      REG_TONE_MIX:   tone_mix_q = val[16:0];
      REG_WET_GAIN:   wet_gain_q = val[16:0];
      REG_OUT_GAIN:   out_gain_q = val[17:0];
      REG_BYPASS:     bypass_q = val[0];
      default: ;
    endcase
  endtask

  // stop sending, let every owed sample come back, then a few spare cycles
  task automatic drain();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (owed_samples.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    burst_left = 0;
  endtask

  // send one sample; bursts of random length separated by random gaps
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp, bit bs, bit typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        in_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_bus.valid       <= 1'b1;
    in_bus.in_sample   <= smp;
    in_bus.block_start <= bs;
    do @(posedge clk_i); while (!in_bus.ready);
    // transfer taken at this edge: predict with the current settings
    if (typed) begin
      void'(distort_sample(smp, bs));
      owed_samples.push_back(smp);
    end else begin
      owed_samples.push_back(distort_sample(smp, bs));
    end
    samples_sent++;
    if (bs) block_starts++;
    if (bypass_q != 0) bypass_seen++;
  endtask

  function automatic logic [DATA_W-1:0] pick(longint lo, longint hi);
    case ($urandom_range(0, 5))
      0:       return DATA_W'(lo);
      1:       return DATA_W'(hi);
      default: return DATA_W'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endcase
  endfunction

  task automatic random_config(bit allow_bypass);
    cfg_write(REG_PRE_GAIN, ($urandom_range(0, 3) == 0) ? pick(0, 33554431)
                                                        : pick(0, 1048576));
    cfg_write(REG_PRE_OFFSET, pick(-458752, 458752));
    cfg_write(REG_SHAPE_NORM, pick(65536, 86074));
    cfg_write(REG_HP_COEFF, pick(0, 65535));
    cfg_write(REG_TONE_MIX, pick(0, 65536));
    cfg_write(REG_WET_GAIN, pick(0, 65536));
    cfg_write(REG_OUT_GAIN, pick(0, 262143));
    cfg_write(REG_BYPASS, (allow_bypass && $urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 5))
      0:       return ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
      1:       return SAMPLE_BITS'($signed($urandom_range(0, 131071)) - 65536);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  // receiver: ready pattern switches among random styles, including no stalls
  int unsigned ready_cyc;
  int unsigned ready_style;
  always @(negedge clk_i) begin
    ready_cyc <= ready_cyc + 1;
    if (ready_cyc % 64 == 0) ready_style <= $urandom_range(0, 3);
    case (ready_style)
      0:       out_bus.ready <= 1'b1;
      1:       out_bus.ready <= $urandom_range(0, 1);
      2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
      default: out_bus.ready <= ready_cyc[4];
    endcase
  end

  // compare each output transfer with the oldest owed sample
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      samples_seen++;
      if (owed_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output sample %0d", out_bus.out_sample);
      end else begin
        if (out_bus.out_sample !== owed_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("out_sample mismatch: expected %0d, got %0d",
                     owed_samples[0], out_bus.out_sample);
        end
        void'(owed_samples.pop_front());
      end
    end
  end

  // watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.in_sample   = '0;
    in_bus.block_start = 1'b0;
    out_bus.ready      = 1'b0;
    ready_cyc          = 0;
    ready_style        = 0;
    mismatches         = 0;
    samples_sent       = 0;
    samples_seen       = 0;
    bypass_seen        = 0;
    block_starts       = 0;
    burst_left         = 0;
    fill_tanh_lut();
    pre_gain_q   = 524288;
    pre_offset_q = 0;
    shape_norm_q = 70345;
    hp_coeff_q   = 65459;
    tone_mix_q   = 36045;
    wet_gain_q   = 45875;
    out_gain_q   = 32845;
    bypass_q     = 0;
    hp_acc       = 0;
    prev_y       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset settings first
    phase = 0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].phase != phase) begin
        drain();
        phase = stim_rows[i].phase;
        if (phase == 1) begin
          cfg_write(REG_BYPASS, 32'd1);
        end else begin
          // extremes: full drive, offset at the top, unity-ish pole, full wet and gain
          cfg_write(REG_BYPASS, 32'd0);
          cfg_write(REG_PRE_GAIN, 32'd33554431);
          cfg_write(REG_PRE_OFFSET, 32'd458752);
          cfg_write(REG_SHAPE_NORM, 32'd86074);
          cfg_write(REG_HP_COEFF, 32'd65535);
          cfg_write(REG_TONE_MIX, 32'd65536);
          cfg_write(REG_WET_GAIN, 32'd65536);
          cfg_write(REG_OUT_GAIN, 32'd262143);
        end
      end
      send_sample(stim_rows[i].smp, stim_rows[i].bs, stim_rows[i].typed);
    end
    drain();
    // other end of the ranges
    cfg_write(REG_PRE_OFFSET, DATA_W'(-458752));
    cfg_write(REG_SHAPE_NORM, 32'd65536);
    cfg_write(REG_HP_COEFF, 32'd0);
    cfg_write(REG_TONE_MIX, 32'd0);
    cfg_write(REG_WET_GAIN, 32'd0);
    cfg_write(REG_OUT_GAIN, 32'd0);
    cfg_write(REG_PRE_GAIN, 32'd0);
    for (int i = 0; i < 6; i++) send_sample(random_sample(), i == 0, 1'b0);

    // random part: phases of fresh settings, mostly long runs between block starts
    for (int p = 0; p < 8; p++) begin
      drain();
      random_config(p != 0);
      for (int i = 0; i < 240; i++)
        send_sample(random_sample(), $urandom_range(0, 31) == 0, 1'b0);
    end

    drain();
    $display("sent %0d samples (%0d in bypass, %0d block starts), received %0d",
             samples_sent, bypass_seen, block_starts, samples_seen);
    $display("settings covered reset values, both range ends and eight random phases");
    if (mismatches == 0 && owed_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d samples never returned", mismatches,
               owed_samples.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
